>>> src/rgbtm_pkg.sv
// ----------------------------------------------------------------------------
// rgbtm_pkg
// Shared types, register indexes, mode codes and the grey snap table for the
// RGB555 tone mapper.
// ----------------------------------------------------------------------------
package rgbtm_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_TONE_MODE    = 3'd0;
   localparam logic [2:0] CSR_RED_GAIN     = 3'd1;
   localparam logic [2:0] CSR_GREEN_GAIN   = 3'd2;
   localparam logic [2:0] CSR_BLUE_GAIN    = 3'd3;
   localparam logic [2:0] CSR_DESAT_AMOUNT = 3'd4;

   // tone mode codes
   localparam logic [2:0] MODE_GREY     = 3'd0;
   localparam logic [2:0] MODE_SNAP     = 3'd1;
   localparam logic [2:0] MODE_SEPIA    = 3'd2;
   localparam logic [2:0] MODE_CUSTOM   = 3'd3;
   localparam logic [2:0] MODE_DESAT    = 3'd4;

   // reset gain, full desaturation amount and channel maximum
   localparam logic [15:0] GAIN_UNITY  = 16'd256;
   localparam logic [4:0]  DESAT_FULL  = 5'd16;
   localparam logic [4:0]  CHAN_MAX    = 5'd31;

   // luma weights (q0.8) and sepia gains (q8.8)
   localparam logic [12:0] LUMA_WR     = 13'd76;
   localparam logic [12:0] LUMA_WG     = 13'd151;
   localparam logic [12:0] LUMA_WB     = 13'd29;
   localparam logic [13:0] SEPIA_RGAIN = 14'd307;
   localparam logic [12:0] SEPIA_BGAIN = 13'd240;

   // grey levels snapped to seven values
   localparam logic [4:0] GREY_SNAP [32] = '{
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd5,  5'd5,  5'd5,  5'd5,  5'd5,
      5'd11, 5'd11, 5'd11, 5'd11, 5'd11,
      5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
      5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
      5'd27, 5'd27, 5'd27, 5'd27, 5'd27,
      5'd31, 5'd31
   };

   // item after the luma stage
   typedef struct packed {
      logic [15:0] pixel;
      logic        last;
      logic [4:0]  gray;
   } luma_item_type;

   // item after the product stage
   typedef struct packed {
      logic [15:0] pixel;
      logic        last;
      logic [4:0]  gray;
      logic [4:0]  snap;
      logic [5:0]  sepia_r;
      logic [4:0]  sepia_b;
      logic [7:0]  gain_r;
      logic [7:0]  gain_g;
      logic [7:0]  gain_b;
      logic [5:0]  desat_r;
      logic [5:0]  desat_g;
      logic [5:0]  desat_b;
   } prod_item_type;

endpackage

>>> src/rgbtm_luma_stage.sv
// ----------------------------------------------------------------------------
// rgbtm_luma_stage
// First pipeline stage: weighted sum of the three channels, giving a 5-bit luma.
// ----------------------------------------------------------------------------
module rgbtm_luma_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    valid_in,
   input  logic [15:0]             pixel_in,
   input  logic                    last_in,
   output logic                    valid_ff,
   output rgbtm_pkg::luma_item_type item_ff
);

   logic [12:0]              luma_sum;
   rgbtm_pkg::luma_item_type item_in;

   // luma = (76r + 151g + 29b) >> 8, never above 31
   always_comb begin
      luma_sum = 13'(pixel_in[4:0])   * rgbtm_pkg::LUMA_WR
               + 13'(pixel_in[9:5])   * rgbtm_pkg::LUMA_WG
               + 13'(pixel_in[14:10]) * rgbtm_pkg::LUMA_WB;
      item_in.pixel = pixel_in;
      item_in.last  = last_in;
      item_in.gray  = luma_sum[12:8];
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> src/rgbtm_prod_stage.sv
// ----------------------------------------------------------------------------
// rgbtm_prod_stage
// Second pipeline stage: gain products, sepia scaling, snap lookup and the
// desaturation step for each channel.
// ----------------------------------------------------------------------------
module rgbtm_prod_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     valid_in,
   input  rgbtm_pkg::luma_item_type item_in,
   input  logic [15:0]              red_gain,
   input  logic [15:0]              green_gain,
   input  logic [15:0]              blue_gain,
   input  logic [4:0]               desat_amount,
   output logic                     valid_ff,
   output rgbtm_pkg::prod_item_type item_ff
);

   // biased step toward grey: (amt*(gray-c) + 512) >> 4, range 1..63
   function automatic logic [5:0] desat_step(input logic [4:0] chan,
                                             input logic [4:0] gray,
                                             input logic [4:0] amt);
      logic signed [10:0] diff_s;
      logic signed [10:0] amt_s;
      logic signed [10:0] prod_s;
      logic signed [10:0] bias_s;
      diff_s = 11'(signed'({1'b0, gray})) - 11'(signed'({1'b0, chan}));
      amt_s  = signed'({6'd0, amt});
      prod_s = amt_s * diff_s;
      bias_s = prod_s + 11'sd512;
      return bias_s[9:4];
   endfunction

   logic [4:0]               amt_sat;
   logic [20:0]              prod_r;
   logic [20:0]              prod_g;
   logic [20:0]              prod_b;
   logic [13:0]              sepia_r_full;
   logic [12:0]              sepia_b_full;
   rgbtm_pkg::prod_item_type item_nxt_in;

   always_comb begin
      // amounts above sixteen mean full grey
      amt_sat = (desat_amount > rgbtm_pkg::DESAT_FULL) ? rgbtm_pkg::DESAT_FULL
                                                       : desat_amount;
      // custom gains, product truncated to 16 bits before the shift
      prod_r = 21'(red_gain)   * 21'(item_in.gray);
      prod_g = 21'(green_gain) * 21'(item_in.gray);
      prod_b = 21'(blue_gain)  * 21'(item_in.gray);
      // sepia scaling
      sepia_r_full = 14'(item_in.gray) * rgbtm_pkg::SEPIA_RGAIN;
      sepia_b_full = 13'(item_in.gray) * rgbtm_pkg::SEPIA_BGAIN;

      item_nxt_in.pixel   = item_in.pixel;
      item_nxt_in.last    = item_in.last;
      item_nxt_in.gray    = item_in.gray;
      item_nxt_in.snap    = rgbtm_pkg::GREY_SNAP[item_in.gray];
      item_nxt_in.sepia_r = sepia_r_full[13:8];
      item_nxt_in.sepia_b = sepia_b_full[12:8];
      item_nxt_in.gain_r  = prod_r[15:8];
      item_nxt_in.gain_g  = prod_g[15:8];
      item_nxt_in.gain_b  = prod_b[15:8];
      item_nxt_in.desat_r = desat_step(item_in.pixel[4:0],   item_in.gray, amt_sat);
      item_nxt_in.desat_g = desat_step(item_in.pixel[9:5],   item_in.gray, amt_sat);
      item_nxt_in.desat_b = desat_step(item_in.pixel[14:10], item_in.gray, amt_sat);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_nxt_in;
      end
   end

endmodule

>>> src/rgbtm_pack_stage.sv
// ----------------------------------------------------------------------------
// rgbtm_pack_stage
// Last pipeline stage: clamping, mode selection and RGB555 packing into the
// output register.
// ----------------------------------------------------------------------------
module rgbtm_pack_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     valid_in,
   input  rgbtm_pkg::prod_item_type item_in,
   input  logic [2:0]               tone_mode,
   input  logic [4:0]               desat_amount,
   output logic                     valid_ff,
   output logic [15:0]              pixel_ff,
   output logic                     last_ff
);

   logic [4:0]  sep_r;
   logic [4:0]  gain_r;
   logic [4:0]  gain_g;
   logic [4:0]  gain_b;
   logic [4:0]  des_r;
   logic [4:0]  des_g;
   logic [4:0]  des_b;
   logic [15:0] pixel_in;

   always_comb begin
      // clamp to the channel range
      sep_r  = item_in.sepia_r[5] ? rgbtm_pkg::CHAN_MAX : item_in.sepia_r[4:0];
      gain_r = (item_in.gain_r[7:5] != 3'd0) ? rgbtm_pkg::CHAN_MAX : item_in.gain_r[4:0];
      gain_g = (item_in.gain_g[7:5] != 3'd0) ? rgbtm_pkg::CHAN_MAX : item_in.gain_g[4:0];
      gain_b = (item_in.gain_b[7:5] != 3'd0) ? rgbtm_pkg::CHAN_MAX : item_in.gain_b[4:0];
      // c + step - 32, kept modulo 32
      des_r = item_in.pixel[4:0]   + item_in.desat_r[4:0];
      des_g = item_in.pixel[9:5]   + item_in.desat_g[4:0];
      des_b = item_in.pixel[14:10] + item_in.desat_b[4:0];

      // mode select
      case (tone_mode)
         rgbtm_pkg::MODE_GREY: begin
            pixel_in = {1'b0, item_in.gray, item_in.gray, item_in.gray};
         end
         rgbtm_pkg::MODE_SNAP: begin
            pixel_in = {1'b0, item_in.snap, item_in.snap, item_in.snap};
         end
         rgbtm_pkg::MODE_SEPIA: begin
            pixel_in = {1'b0, item_in.sepia_b, item_in.gray, sep_r};
         end
         rgbtm_pkg::MODE_CUSTOM: begin
            pixel_in = {1'b0, gain_b, gain_g, gain_r};
         end
         rgbtm_pkg::MODE_DESAT: begin
            // zero amount passes the word through, bit 15 included
            if (desat_amount == 5'd0) begin
               pixel_in = item_in.pixel;
            end else begin
               pixel_in = {1'b0, des_b, des_g, des_r};
            end
         end
         default: begin
            pixel_in = item_in.pixel;
         end
      endcase
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (enable) begin
         pixel_ff <= pixel_in;
         last_ff  <= item_in.last;
      end
   end

endmodule

>>> src/rgb555_tone_mapper.sv
// ----------------------------------------------------------------------------
// rgb555_tone_mapper
// Per-colour tone mapping of RGB555 words: grey, snapped grey, sepia, custom
// three-gain tone, partial desaturation, or pass-through for unused modes.
// ----------------------------------------------------------------------------
// The block takes one colour item per clock unless every stage is full and
// the result side is not ready. It gives one toned item per colour, in
// order, after the luma stage, the product stage (gain multipliers, sepia
// scaling, desaturation step) and the pack stage, whose register drives the
// rsp_ ports. Each stage holds its item while the stage after it is full and
// stalled, so up to three items are in flight. The user must write registers
// through the csr_ port only while no item is in flight; the block itself
// does not enforce it. Indexes five to seven are ignored.
// ----------------------------------------------------------------------------
module rgb555_tone_mapper (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_pixel_in,
   input  logic        req_last_in,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_out,
   output logic        rsp_last_out,
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [2:0]  tone_mode_ff;
   logic [15:0] red_gain_ff;
   logic [15:0] green_gain_ff;
   logic [15:0] blue_gain_ff;
   logic [4:0]  desat_amount_ff;

   logic                     luma_valid;
   logic                     prod_valid;
   logic                     en_luma;
   logic                     en_prod;
   logic                     en_pack;
   rgbtm_pkg::luma_item_type luma_item;
   rgbtm_pkg::prod_item_type prod_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_mode_ff    <= rgbtm_pkg::MODE_GREY;
         red_gain_ff     <= rgbtm_pkg::GAIN_UNITY;
         green_gain_ff   <= rgbtm_pkg::GAIN_UNITY;
         blue_gain_ff    <= rgbtm_pkg::GAIN_UNITY;
         desat_amount_ff <= 5'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            rgbtm_pkg::CSR_TONE_MODE:    tone_mode_ff    <= csr_wdata[2:0];
            rgbtm_pkg::CSR_RED_GAIN:     red_gain_ff     <= csr_wdata;
            rgbtm_pkg::CSR_GREEN_GAIN:   green_gain_ff   <= csr_wdata;
            rgbtm_pkg::CSR_BLUE_GAIN:    blue_gain_ff    <= csr_wdata;
            rgbtm_pkg::CSR_DESAT_AMOUNT: desat_amount_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   // stage advance: a stage moves when it is empty or the next one moves
   assign en_pack   = !rsp_valid || rsp_ready;
   assign en_prod   = !prod_valid || en_pack;
   assign en_luma   = !luma_valid || en_prod;
   assign req_ready = en_luma;

   rgbtm_luma_stage u_luma (
      .clock    (clock),
      .reset    (reset),
      .enable   (en_luma),
      .valid_in (req_valid),
      .pixel_in (req_pixel_in),
      .last_in  (req_last_in),
      .valid_ff (luma_valid),
      .item_ff  (luma_item)
   );

   rgbtm_prod_stage u_prod (
      .clock        (clock),
      .reset        (reset),
      .enable       (en_prod),
      .valid_in     (luma_valid),
      .item_in      (luma_item),
      .red_gain     (red_gain_ff),
      .green_gain   (green_gain_ff),
      .blue_gain    (blue_gain_ff),
      .desat_amount (desat_amount_ff),
      .valid_ff     (prod_valid),
      .item_ff      (prod_item)
   );

   rgbtm_pack_stage u_pack (
      .clock        (clock),
      .reset        (reset),
      .enable       (en_pack),
      .valid_in     (prod_valid),
      .item_in      (prod_item),
      .tone_mode    (tone_mode_ff),
      .desat_amount (desat_amount_ff),
      .valid_ff     (rsp_valid),
      .pixel_ff     (rsp_pixel_out),
      .last_ff      (rsp_last_out)
   );

   // full pipeline with a stalled output takes no new item
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (luma_valid && prod_valid && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("item taken while pipeline full and stalled");

   // a stalled product stage keeps its item
   a_prod_hold: assert property (@(posedge clock) disable iff (reset)
      (prod_valid && !en_prod) |=> (prod_valid && $stable(prod_item)))
      else $error("product stage lost its item during a stall");

   // grey mode gives equal channels and a clear top bit
   a_grey_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && tone_mode_ff == rgbtm_pkg::MODE_GREY) |->
      (rsp_pixel_out[4:0] == rsp_pixel_out[9:5] &&
       rsp_pixel_out[9:5] == rsp_pixel_out[14:10] && !rsp_pixel_out[15]))
      else $error("grey mode channels differ");

   // sepia red never falls below green
   a_sepia_warm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && tone_mode_ff == rgbtm_pkg::MODE_SEPIA) |->
      (rsp_pixel_out[4:0] >= rsp_pixel_out[9:5] && !rsp_pixel_out[15]))
      else $error("sepia red below green");

endmodule
